// ===== rtl/umsw_pkg.sv =====
// ----------------------------------------------------------------------------
// umsw_pkg: shared types and constants of the SysEx setting watcher
// Holds USB-MIDI code indexes, SysEx framing bytes, setting keys, the fixed
// message header and the command that passes from the front to the back part.
// ----------------------------------------------------------------------------
`default_nettype none

package umsw_pkg;

  // Default message geometry
  localparam int MessageBytesDefault = 22;
  localparam int CaptureBytesDefault = 32;

  // Byte counter: wide enough for the largest capture size (63)
  localparam int CountW = 6;

  // Command queue between front and back
  localparam int QueueDepth = 2;
  localparam int QueuePtrW  = $clog2(QueueDepth);
  localparam int QueueCntW  = QueuePtrW + 1;

  // USB-MIDI code index numbers for SysEx
  localparam logic [3:0] CIN_SYSEX_CONT = 4'h4;
  localparam logic [3:0] CIN_SYSEX_END1 = 4'h5;
  localparam logic [3:0] CIN_SYSEX_END2 = 4'h6;
  localparam logic [3:0] CIN_SYSEX_END3 = 4'h7;

  localparam logic [3:0] CABLE_WATCHED = 4'h0;

  // SysEx framing
  localparam logic [7:0] SYSEX_START = 8'hF0;
  localparam logic [7:0] SYSEX_END   = 8'hF7;

  // Setting keys
  localparam logic [7:0] KEY_ROUTE  = 8'h12;
  localparam logic [7:0] KEY_SOURCE = 8'h14;

  // Header positions and fixed key/value positions within a message
  localparam int HeaderLen = 7;
  localparam int KeyPos    = 7;
  localparam int ValuePos  = 8;

  // Fixed header F0 00 21 1D 01 01 37
  function automatic logic [7:0] header_byte(input logic [2:0] idx);
    logic [7:0] b;
    case (idx)
      3'd0:    b = SYSEX_START;
      3'd1:    b = 8'h00;
      3'd2:    b = 8'h21;
      3'd3:    b = 8'h1D;
      3'd4:    b = 8'h01;
      3'd5:    b = 8'h01;
      3'd6:    b = 8'h37;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  // One classified request, front to back
  typedef struct packed {
    logic route_upd;   // valid route message seen
    logic source_upd;  // valid out-source message seen
    logic source_sel;  // bit 0 of value byte
    logic monitor;     // bit 1 of value byte
    logic frame_last;
  } cmd_t;

endpackage

`default_nettype wire

// ===== rtl/umsw_if.sv =====
// ----------------------------------------------------------------------------
// umsw_if: packet and result channels of the SysEx setting watcher
// Valid/ready channels; a request moves on a clock edge with both high.
// ----------------------------------------------------------------------------
`default_nettype none

interface umsw_pkt_if;
  logic       valid;
  logic       ready;
  logic [7:0] packet_head;
  logic [7:0] payload_first;
  logic [7:0] payload_second;
  logic [7:0] payload_third;
  logic       frame_last;

  modport source (
    output valid, packet_head, payload_first, payload_second, payload_third,
           frame_last,
    input  ready
  );
  modport sink (
    input  valid, packet_head, payload_first, payload_second, payload_third,
           frame_last,
    output ready
  );
endinterface

interface umsw_res_if;
  logic        valid;
  logic        ready;
  logic        out_source;
  logic        monitor_bit;
  logic        route_seen;
  logic        frame_changed;
  logic [31:0] change_count;

  modport source (
    output valid, out_source, monitor_bit, route_seen, frame_changed, change_count,
    input  ready
  );
  modport sink (
    input  valid, out_source, monitor_bit, route_seen, frame_changed, change_count,
    output ready
  );
endinterface

`default_nettype wire

// ===== rtl/umsw_front.sv =====
// ----------------------------------------------------------------------------
// umsw_front: packet intake and SysEx reassembly check
// Follows cable-0 SysEx bytes, checks header, length and trailer on the fly
// and turns every packet into one command for the back part.
// ----------------------------------------------------------------------------
`default_nettype none

module umsw_front #(
  parameter int MESSAGE_BYTES = umsw_pkg::MessageBytesDefault,
  parameter int CAPTURE_BYTES = umsw_pkg::CaptureBytesDefault
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  umsw_pkt_if.sink            pkt_i,
  output umsw_pkg::cmd_t      cmd_o,
  output logic                cmd_valid_o,
  input  wire logic           cmd_ready_i
);
  import umsw_pkg::*;

  localparam int PosW = CountW + 1;

  logic              capturing_q, capturing_d;
  logic [CountW-1:0] count_q, count_d;
  logic              hdr_ok_q, hdr_ok_d;
  logic [7:0]        key_q, key_d;
  logic [7:0]        value_q, value_d;
  logic [7:0]        tail_q, tail_d;

  logic [3:0]        cin;
  logic [3:0]        cable;
  logic [1:0]        n_bytes;
  logic              is_sysex;
  logic              restart;
  logic              active;
  logic              is_end;
  logic              msg_ok;
  logic              accept;
  logic [7:0]        data [3];

  assign cin   = pkt_i.packet_head[3:0];
  assign cable = pkt_i.packet_head[7:4];
  assign data[0] = pkt_i.payload_first;
  assign data[1] = pkt_i.payload_second;
  assign data[2] = pkt_i.payload_third;

  always_comb begin
    unique case (cin)
      CIN_SYSEX_CONT: n_bytes = 2'd3;
      CIN_SYSEX_END1: n_bytes = 2'd1;
      CIN_SYSEX_END2: n_bytes = 2'd2;
      CIN_SYSEX_END3: n_bytes = 2'd3;
      default:        n_bytes = 2'd0;
    endcase
  end

  assign is_sysex = (n_bytes != 2'd0) && (cable == CABLE_WATCHED);
  assign restart  = is_sysex && (data[0] == SYSEX_START);
  assign active   = is_sysex && (capturing_q || restart);
  assign is_end   = active && (cin != CIN_SYSEX_CONT);

  // Take up to three bytes; positions past the capture size are dropped
  always_comb begin
    logic [PosW-1:0] pos;
    count_d  = restart ? '0 : count_q;
    hdr_ok_d = restart ? 1'b1 : hdr_ok_q;
    key_d    = key_q;
    value_d  = value_q;
    tail_d   = tail_q;
    for (int k = 0; k < 3; k++) begin
      pos = {1'b0, count_d};
      if (active && (k < int'(n_bytes)) && (pos < PosW'(CAPTURE_BYTES))) begin
        if (pos < PosW'(HeaderLen) && data[k] != header_byte(pos[2:0])) begin
          hdr_ok_d = 1'b0;
        end
        if (pos == PosW'(KeyPos)) begin
          key_d = data[k];
        end
        if (pos == PosW'(ValuePos)) begin
          value_d = data[k];
        end
        if (pos == PosW'(MESSAGE_BYTES - 1)) begin
          tail_d = data[k];
        end
        count_d = CountW'(pos + PosW'(1));
      end
    end
  end

  always_comb begin
    capturing_d = capturing_q;
    if (is_end) begin
      capturing_d = 1'b0;
    end else if (restart) begin
      capturing_d = 1'b1;
    end
  end

  assign msg_ok = is_end && hdr_ok_d && (count_d == CountW'(MESSAGE_BYTES)) &&
                  (tail_d == SYSEX_END);

  assign cmd_o.route_upd  = msg_ok && (key_d == KEY_ROUTE);
  assign cmd_o.source_upd = msg_ok && (key_d == KEY_SOURCE);
  assign cmd_o.source_sel = value_d[0];
  assign cmd_o.monitor    = value_d[1];
  assign cmd_o.frame_last = pkt_i.frame_last;

  assign cmd_valid_o = pkt_i.valid;
  assign pkt_i.ready = cmd_ready_i;
  assign accept      = pkt_i.valid && cmd_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capturing_q <= 1'b0;
      count_q     <= '0;
      hdr_ok_q    <= 1'b1;
      key_q       <= '0;
      value_q     <= '0;
      tail_q      <= '0;
    end else if (accept) begin
      capturing_q <= capturing_d;
      count_q     <= count_d;
      hdr_ok_q    <= hdr_ok_d;
      key_q       <= key_d;
      value_q     <= value_d;
      tail_q      <= tail_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/umsw_queue.sv =====
// ----------------------------------------------------------------------------
// umsw_queue: command queue between front and back
// Short FIFO that lets the intake and the setting update stall separately.
// ----------------------------------------------------------------------------
`default_nettype none

module umsw_queue (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire umsw_pkg::cmd_t  wr_cmd_i,
  input  wire logic            wr_valid_i,
  output logic                 wr_ready_o,
  output umsw_pkg::cmd_t       rd_cmd_o,
  output logic                 rd_valid_o,
  input  wire logic            rd_ready_i
);
  import umsw_pkg::*;

  cmd_t                 mem_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QueueCntW-1:0] cnt_q;
  logic                 push, pop;

  assign wr_ready_o = (cnt_q != QueueCntW'(QueueDepth));
  assign rd_valid_o = (cnt_q != '0);
  assign rd_cmd_o   = mem_q[rd_ptr_q];
  assign push       = wr_valid_i && wr_ready_o;
  assign pop        = rd_valid_o && rd_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= wr_cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + QueuePtrW'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + QueuePtrW'(1);
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + QueueCntW'(1);
      end else if (pop && !push) begin
        cnt_q <= cnt_q - QueueCntW'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/umsw_back.sv =====
// ----------------------------------------------------------------------------
// umsw_back: setting update and result register
// Applies route and out-source commands, counts selection changes, tracks
// changes per transfer frame and presents one registered result per command.
// ----------------------------------------------------------------------------
`default_nettype none

module umsw_back (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire umsw_pkg::cmd_t  cmd_i,
  input  wire logic            cmd_valid_i,
  output logic                 cmd_ready_o,
  umsw_res_if.source           res_o
);
  import umsw_pkg::*;

  logic        source_q, source_d;
  logic        monitor_q, monitor_d;
  logic        route_q, route_d;
  logic [31:0] changes_q, changes_d;
  logic        frame_chg_q, frame_chg_d;
  logic        res_valid_q;
  logic        res_frame_q;
  logic        any_chg;
  logic        changed;
  logic        pop;

  // Take a command whenever the result register is empty or being drained
  assign cmd_ready_o = !res_valid_q || res_o.ready;
  assign pop         = cmd_valid_i && cmd_ready_o;

  always_comb begin
    changed   = cmd_i.source_upd && (cmd_i.source_sel != source_q);
    source_d  = changed ? cmd_i.source_sel : source_q;
    changes_d = changed ? changes_q + 32'd1 : changes_q;
    route_d   = route_q || cmd_i.route_upd;
    monitor_d = cmd_i.route_upd ? cmd_i.monitor : monitor_q;
    any_chg   = frame_chg_q || changed;
    // clear the frame flag once the frame's last packet is reported
    frame_chg_d = cmd_i.frame_last ? 1'b0 : any_chg;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      source_q    <= 1'b0;
      monitor_q   <= 1'b0;
      route_q     <= 1'b0;
      changes_q   <= '0;
      frame_chg_q <= 1'b0;
      res_valid_q <= 1'b0;
      res_frame_q <= 1'b0;
    end else begin
      if (pop) begin
        source_q    <= source_d;
        monitor_q   <= monitor_d;
        route_q     <= route_d;
        changes_q   <= changes_d;
        frame_chg_q <= frame_chg_d;
        res_frame_q <= cmd_i.frame_last && any_chg;
        res_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  assign res_o.valid         = res_valid_q;
  assign res_o.out_source    = source_q;
  assign res_o.monitor_bit   = monitor_q;
  assign res_o.route_seen    = route_q;
  assign res_o.frame_changed = res_frame_q;
  assign res_o.change_count  = changes_q;

endmodule

`default_nettype wire

// ===== rtl/usb_midi_sysex_setting_watcher_unit.sv =====
// ----------------------------------------------------------------------------
// usb_midi_sysex_setting_watcher_unit: USB-MIDI SysEx setting watcher
// pkt_i takes one 4-byte USB-MIDI packet per request; res_o returns exactly
// one result per packet, in order: out-source selection, monitor bit, route
// seen flag, frame-changed flag (on the frame's last packet) and a 32-bit
// count of selection changes.
// The front part checks cable-0 SysEx bytes against the fixed header, the
// message length and the trailing F7 as they arrive, so a packet is taken
// every cycle while the queue has room. A two-entry command queue separates
// it from the back part, which updates the settings and loads the result
// register. The queue entry and the result register lie between an
// accepted packet and its result. Throughput: 1 packet per cycle while
// res_o is drained every cycle; the setting update in the back part sets it.
// When the receiver stalls the result holds, the queue fills, and pkt_i.ready
// drops once both queue entries are taken.
// Reset clears capture, settings, the change count and both channels.
// ----------------------------------------------------------------------------
`default_nettype none

module usb_midi_sysex_setting_watcher_unit #(
  parameter int MESSAGE_BYTES = umsw_pkg::MessageBytesDefault,
  parameter int CAPTURE_BYTES = umsw_pkg::CaptureBytesDefault
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  umsw_pkt_if.sink   pkt_i,
  umsw_res_if.source res_o
);
  import umsw_pkg::*;

  cmd_t front_cmd;
  logic front_valid;
  logic front_ready;
  cmd_t back_cmd;
  logic back_valid;
  logic back_ready;

  umsw_front #(
    .MESSAGE_BYTES (MESSAGE_BYTES),
    .CAPTURE_BYTES (CAPTURE_BYTES)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pkt_i       (pkt_i),
    .cmd_o       (front_cmd),
    .cmd_valid_o (front_valid),
    .cmd_ready_i (front_ready)
  );

  umsw_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_cmd_i   (front_cmd),
    .wr_valid_i (front_valid),
    .wr_ready_o (front_ready),
    .rd_cmd_o   (back_cmd),
    .rd_valid_o (back_valid),
    .rd_ready_i (back_ready)
  );

  umsw_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (back_cmd),
    .cmd_valid_i (back_valid),
    .cmd_ready_o (back_ready),
    .res_o       (res_o)
  );

endmodule

`default_nettype wire
